// ===== sv/iou_pkg.sv =====
// Shared types and constants of the IoU track event table.
// Holds the controller/datapath command and status structs and the field codes.
package iou_pkg;

    localparam logic OP_DETECT = 1'b0;
    localparam logic OP_SWEEP  = 1'b1;

    localparam logic [1:0] EVT_START   = 2'd0;
    localparam logic [1:0] EVT_UPDATE  = 2'd1;
    localparam logic [1:0] EVT_END     = 2'd2;
    localparam logic [1:0] EVT_DROPPED = 2'd3;

    localparam logic [1:0] REG_IOU_THR  = 2'd0;
    localparam logic [1:0] REG_UPD_INT  = 2'd1;
    localparam logic [1:0] REG_LOST_TO  = 2'd2;

    localparam int         ADDR_W        = 4;
    localparam logic [15:0] RST_IOU_THR  = 16'd19661;
    localparam logic [15:0] RST_UPD_INT  = 16'd1000;
    localparam logic [15:0] RST_LOST_TO  = 16'd2000;

    typedef struct packed {
        logic load_item;
        logic prep;
        logic rd;
        logic geo;
        logic uni;
        logic thr;
        logic m1a;
        logic m1b;
        logic m2a;
        logic m2b;
        logic take_best;
        logic next_idx;
        logic keep;
        logic hold;
        logic rotate;
        logic emit_last;
        logic fin_det;
        logic fin_sweep;
    } t_cmd;

    typedef struct packed {
        logic is_sweep;
        logic zero_conf;
        logic idx_done;
        logic candidate;
        logic better;
        logic expired;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/iou_det_if.sv =====
// Detection input channel of the IoU track event table.
// Carries valid, ready and one detection or end-of-frame item.
interface iou_det_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [7:0]            class_id;
    logic [15:0]           confidence;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] x2;
    logic [COORD_BITS-1:0] y2;
    logic [12:0]           frame_w;
    logic [12:0]           frame_h;
    logic [31:0]           now_ms;

    modport source (output valid, op, class_id, confidence, x1, y1, x2, y2,
                    frame_w, frame_h, now_ms, input ready);
    modport sink (input valid, op, class_id, confidence, x1, y1, x2, y2,
                  frame_w, frame_h, now_ms, output ready);
endinterface

// ===== sv/iou_evt_if.sv =====
// Event output channel of the IoU track event table.
// Carries valid, ready and one track event item.
interface iou_evt_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [1:0]            evt_kind;
    logic [31:0]           track_id;
    logic [7:0]            out_class;
    logic [15:0]           out_confidence;
    logic [COORD_BITS-1:0] out_x1;
    logic [COORD_BITS-1:0] out_y1;
    logic [COORD_BITS-1:0] out_x2;
    logic [COORD_BITS-1:0] out_y2;
    logic [12:0]           out_frame_w;
    logic [12:0]           out_frame_h;
    logic                  last;

    modport source (output valid, evt_kind, track_id, out_class, out_confidence,
                    out_x1, out_y1, out_x2, out_y2, out_frame_w, out_frame_h, last,
                    input ready);
    modport sink (input valid, evt_kind, track_id, out_class, out_confidence,
                  out_x1, out_y1, out_x2, out_y2, out_frame_w, out_frame_h, last,
                  output ready);
endinterface

// ===== sv/iou_ctrl.sv =====
// Sequencing state machine of the IoU track event table.
// Depends on iou_pkg for the command and status structs.
module iou_ctrl import iou_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_DECODE = 16'h0002,
        ST_D_CHK  = 16'h0004,
        ST_D_GEO  = 16'h0008,
        ST_D_UNI  = 16'h0010,
        ST_D_THR  = 16'h0020,
        ST_D_FLT  = 16'h0040,
        ST_D_M1A  = 16'h0080,
        ST_D_M1B  = 16'h0100,
        ST_D_M2A  = 16'h0200,
        ST_D_M2B  = 16'h0400,
        ST_D_CMP  = 16'h0800,
        ST_D_FIN  = 16'h1000,
        ST_S_CHK  = 16'h2000,
        ST_S_DEC  = 16'h4000,
        ST_S_END  = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.prep = 1'b1;
                if (i_sts.is_sweep) begin
                    n_state = ST_S_CHK;
                end else if (i_sts.zero_conf) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_D_CHK;
                end
            end
            ST_D_CHK: begin
                if (i_sts.idx_done) begin
                    n_state = ST_D_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = ST_D_GEO;
                end
            end
            ST_D_GEO: begin
                o_cmd.geo = 1'b1;
                n_state = ST_D_UNI;
            end
            ST_D_UNI: begin
                o_cmd.uni = 1'b1;
                n_state = ST_D_THR;
            end
            ST_D_THR: begin
                o_cmd.thr = 1'b1;
                n_state = ST_D_FLT;
            end
            ST_D_FLT: begin
                if (i_sts.candidate) begin
                    n_state = ST_D_M1A;
                end else begin
                    o_cmd.next_idx = 1'b1;
                    n_state = ST_D_CHK;
                end
            end
            ST_D_M1A: begin
                o_cmd.m1a = 1'b1;
                n_state = ST_D_M1B;
            end
            ST_D_M1B: begin
                o_cmd.m1b = 1'b1;
                n_state = ST_D_M2A;
            end
            ST_D_M2A: begin
                o_cmd.m2a = 1'b1;
                n_state = ST_D_M2B;
            end
            ST_D_M2B: begin
                o_cmd.m2b = 1'b1;
                n_state = ST_D_CMP;
            end
            ST_D_CMP: begin
                o_cmd.take_best = i_sts.better;
                o_cmd.next_idx  = 1'b1;
                n_state = ST_D_CHK;
            end
            ST_D_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_det = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_S_CHK: begin
                if (i_sts.idx_done) begin
                    n_state = ST_S_END;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = ST_S_DEC;
                end
            end
            ST_S_DEC: begin
                if (!i_sts.expired) begin
                    o_cmd.keep     = 1'b1;
                    o_cmd.next_idx = 1'b1;
                    n_state = ST_S_CHK;
                end else if (!i_sts.pend_valid) begin
                    o_cmd.hold     = 1'b1;
                    o_cmd.next_idx = 1'b1;
                    n_state = ST_S_CHK;
                end else if (i_sts.out_free) begin
                    o_cmd.rotate   = 1'b1;
                    o_cmd.next_idx = 1'b1;
                    n_state = ST_S_CHK;
                end
            end
            ST_S_END: begin
                if (!i_sts.pend_valid) begin
                    o_cmd.fin_sweep = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_last = 1'b1;
                    o_cmd.fin_sweep = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/iou_dp.sv =====
// Datapath of the IoU track event table: track memory, IoU arithmetic and event register.
// Depends on iou_pkg; driven by iou_ctrl through t_cmd and answers through t_sts.
module iou_dp import iou_pkg::*; #(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [15:0]           i_iou_thr,
    input  logic [15:0]           i_upd_int,
    input  logic [15:0]           i_lost_to,
    input  logic                  i_op,
    input  logic [7:0]            i_class_id,
    input  logic [15:0]           i_confidence,
    input  logic [COORD_BITS-1:0] i_x1,
    input  logic [COORD_BITS-1:0] i_y1,
    input  logic [COORD_BITS-1:0] i_x2,
    input  logic [COORD_BITS-1:0] i_y2,
    input  logic [12:0]           i_frame_w,
    input  logic [12:0]           i_frame_h,
    input  logic [31:0]           i_now_ms,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_evt_kind,
    output logic [31:0]           o_track_id,
    output logic [7:0]            o_out_class,
    output logic [15:0]           o_out_confidence,
    output logic [COORD_BITS-1:0] o_out_x1,
    output logic [COORD_BITS-1:0] o_out_y1,
    output logic [COORD_BITS-1:0] o_out_x2,
    output logic [COORD_BITS-1:0] o_out_y2,
    output logic [12:0]           o_out_frame_w,
    output logic [12:0]           o_out_frame_h,
    output logic                  o_last
);

    localparam int CB  = COORD_BITS;
    localparam int IW  = $clog2(MAX_TRACKS);
    localparam int CW  = $clog2(MAX_TRACKS + 1);
    localparam int AW  = 2 * CB;
    localparam int UW  = AW + 1;
    localparam int HW  = CB + 1;
    localparam int PW  = AW + UW;
    localparam int MPW = AW + HW;
    localparam int BW  = 4 * CB;
    localparam int TW  = UW + 16;

    // Track memory, one row per slot.
    logic [7:0]    mem_cls   [MAX_TRACKS];
    logic [BW-1:0] mem_box   [MAX_TRACKS];
    logic [15:0]   mem_conf  [MAX_TRACKS];
    logic [25:0]   mem_fs    [MAX_TRACKS];
    logic [31:0]   mem_tid   [MAX_TRACKS];
    logic [31:0]   mem_lseen [MAX_TRACKS];
    logic [31:0]   mem_lrep  [MAX_TRACKS];
    logic          mem_match [MAX_TRACKS];

    logic [7:0]    r_rd_cls;
    logic [BW-1:0] r_rd_box;
    logic [15:0]   r_rd_conf;
    logic [25:0]   r_rd_fs;
    logic [31:0]   r_rd_tid;
    logic [31:0]   r_rd_lseen;
    logic [31:0]   r_rd_lrep;
    logic          r_rd_match;

    // Current item.
    logic          r_op;
    logic [7:0]    r_cls;
    logic [15:0]   r_conf;
    logic [BW-1:0] r_box;
    logic [25:0]   r_fs;
    logic [31:0]   r_now;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_w;
    logic [31:0]   r_next_id;

    logic [AW-1:0] r_area_d;
    logic [AW-1:0] r_area_s;
    logic [AW-1:0] r_inter;
    logic [UW-1:0] r_uni;
    logic [TW-1:0] r_pthr;
    logic [PW-1:0] r_acc;
    logic [PW-1:0] r_p1;
    logic [PW-1:0] r_p2;

    logic          r_have_best;
    logic [IW-1:0] r_best_idx;
    logic [AW-1:0] r_best_i;
    logic [UW-1:0] r_best_u;
    logic [31:0]   r_best_tid;
    logic [31:0]   r_best_lrep;

    logic          r_pv;
    logic [7:0]    r_pd_cls;
    logic [BW-1:0] r_pd_box;
    logic [15:0]   r_pd_conf;
    logic [25:0]   r_pd_fs;
    logic [31:0]   r_pd_tid;

    logic          r_ov;
    logic [1:0]    r_o_type;
    logic [31:0]   r_o_tid;
    logic [7:0]    r_o_cls;
    logic [15:0]   r_o_conf;
    logic [BW-1:0] r_o_box;
    logic [25:0]   r_o_fs;
    logic          r_o_last;

    logic [CB-1:0] sx1, sy1, sx2, sy2, dx1, dy1, dx2, dy2;
    logic [CB-1:0] il, it, ir, ib, iw, ih, sw, sh, dw, dh;
    logic [AW-1:0] inter_c, area_s_c, area_d_c;
    logic          full, upd_due, out_free, out_ld;
    logic          m_sel2, m_hi;
    logic [AW-1:0] mul_a;
    logic [UW-1:0] mul_bsrc;
    logic [HW-1:0] mul_b;
    logic [MPW-1:0] mul_p;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [7:0]    wr_cls;
    logic [BW-1:0] wr_box;
    logic [15:0]   wr_conf;
    logic [25:0]   wr_fs;
    logic [31:0]   wr_tid;
    logic [31:0]   wr_lseen;
    logic [31:0]   wr_lrep;
    logic          wr_match;

    // Box geometry.
    always_comb begin
        sx1 = r_rd_box[0 +: CB];
        sy1 = r_rd_box[CB +: CB];
        sx2 = r_rd_box[2*CB +: CB];
        sy2 = r_rd_box[3*CB +: CB];
        dx1 = r_box[0 +: CB];
        dy1 = r_box[CB +: CB];
        dx2 = r_box[2*CB +: CB];
        dy2 = r_box[3*CB +: CB];
        il  = (sx1 > dx1) ? sx1 : dx1;
        it  = (sy1 > dy1) ? sy1 : dy1;
        ir  = (sx2 < dx2) ? sx2 : dx2;
        ib  = (sy2 < dy2) ? sy2 : dy2;
        iw  = (ir > il) ? ir - il : '0;
        ih  = (ib > it) ? ib - it : '0;
        sw  = (sx2 > sx1) ? sx2 - sx1 : '0;
        sh  = (sy2 > sy1) ? sy2 - sy1 : '0;
        dw  = (dx2 > dx1) ? dx2 - dx1 : '0;
        dh  = (dy2 > dy1) ? dy2 - dy1 : '0;
        inter_c  = AW'(iw) * AW'(ih);
        area_s_c = AW'(sw) * AW'(sh);
        area_d_c = AW'(dw) * AW'(dh);
    end

    // Shared multiplier, one half of the wide operand per cycle.
    always_comb begin
        m_sel2   = i_cmd.m2a | i_cmd.m2b;
        m_hi     = i_cmd.m1b | i_cmd.m2b;
        mul_a    = m_sel2 ? r_best_i : r_inter;
        mul_bsrc = m_sel2 ? r_uni : r_best_u;
        mul_b    = m_hi ? HW'(mul_bsrc[UW-1:HW]) : mul_bsrc[HW-1:0];
        mul_p    = MPW'(mul_a) * MPW'(mul_b);
    end

    assign full     = (r_count == CW'(MAX_TRACKS));
    assign upd_due  = ((r_now - r_best_lrep) >= {16'h0, i_upd_int});
    assign out_free = !r_ov || i_ready;
    assign out_ld   = i_cmd.rotate || i_cmd.emit_last ||
                      (i_cmd.fin_det && (!r_have_best || upd_due));

    always_comb begin
        o_sts.is_sweep   = (r_op == OP_SWEEP);
        o_sts.zero_conf  = (r_conf == 16'h0);
        o_sts.idx_done   = (r_idx == r_count);
        o_sts.candidate  = (r_rd_cls == r_cls) && (r_inter != '0) && (r_uni != '0) &&
                           ({1'b0, r_inter, 16'h0} >= r_pthr);
        o_sts.better     = (r_p1 > r_p2);
        o_sts.expired    = !r_rd_match && ((r_now - r_rd_lseen) >= {16'h0, i_lost_to});
        o_sts.pend_valid = r_pv;
        o_sts.out_free   = out_free;
    end

    // Row write: compaction during the sweep, match update or new track otherwise.
    always_comb begin
        wr_en    = i_cmd.keep || (i_cmd.fin_det && (r_have_best || !full));
        wr_addr  = r_count[IW-1:0];
        wr_cls   = r_cls;
        wr_box   = r_box;
        wr_conf  = r_conf;
        wr_fs    = r_fs;
        wr_tid   = r_next_id;
        wr_lseen = r_now;
        wr_lrep  = r_now;
        wr_match = 1'b1;
        if (i_cmd.keep) begin
            wr_addr  = r_w[IW-1:0];
            wr_cls   = r_rd_cls;
            wr_box   = r_rd_box;
            wr_conf  = r_rd_conf;
            wr_fs    = r_rd_fs;
            wr_tid   = r_rd_tid;
            wr_lseen = r_rd_lseen;
            wr_lrep  = r_rd_lrep;
            wr_match = 1'b0;
        end else if (r_have_best) begin
            wr_addr = r_best_idx;
            wr_tid  = r_best_tid;
            wr_lrep = upd_due ? r_now : r_best_lrep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_cls[wr_addr]   <= wr_cls;
            mem_box[wr_addr]   <= wr_box;
            mem_conf[wr_addr]  <= wr_conf;
            mem_fs[wr_addr]    <= wr_fs;
            mem_tid[wr_addr]   <= wr_tid;
            mem_lseen[wr_addr] <= wr_lseen;
            mem_lrep[wr_addr]  <= wr_lrep;
            mem_match[wr_addr] <= wr_match;
        end
        if (i_cmd.rd) begin
            r_rd_cls   <= mem_cls[r_idx[IW-1:0]];
            r_rd_box   <= mem_box[r_idx[IW-1:0]];
            r_rd_conf  <= mem_conf[r_idx[IW-1:0]];
            r_rd_fs    <= mem_fs[r_idx[IW-1:0]];
            r_rd_tid   <= mem_tid[r_idx[IW-1:0]];
            r_rd_lseen <= mem_lseen[r_idx[IW-1:0]];
            r_rd_lrep  <= mem_lrep[r_idx[IW-1:0]];
            r_rd_match <= mem_match[r_idx[IW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_cls  <= i_class_id;
            r_conf <= i_confidence;
            r_box  <= {i_y2, i_x2, i_y1, i_x1};
            r_fs   <= {i_frame_h, i_frame_w};
            r_now  <= i_now_ms;
        end
        if (i_cmd.prep) begin
            r_area_d <= area_d_c;
            r_best_i <= '0;
            r_best_u <= UW'(1);
        end
        if (i_cmd.geo) begin
            r_inter  <= inter_c;
            r_area_s <= area_s_c;
        end
        if (i_cmd.uni) begin
            r_uni <= UW'(r_area_s) + UW'(r_area_d) - UW'(r_inter);
        end
        if (i_cmd.thr) begin
            r_pthr <= TW'(i_iou_thr) * TW'(r_uni);
        end
        if (i_cmd.m1a || i_cmd.m2a) begin
            r_acc <= PW'(mul_p);
        end
        if (i_cmd.m1b) begin
            r_p1 <= r_acc + (PW'(mul_p) << HW);
        end
        if (i_cmd.m2b) begin
            r_p2 <= r_acc + (PW'(mul_p) << HW);
        end
        if (i_cmd.take_best) begin
            r_best_idx  <= r_idx[IW-1:0];
            r_best_i    <= r_inter;
            r_best_u    <= r_uni;
            r_best_tid  <= r_rd_tid;
            r_best_lrep <= r_rd_lrep;
        end
        if (i_cmd.hold || i_cmd.rotate) begin
            r_pd_cls  <= r_rd_cls;
            r_pd_box  <= r_rd_box;
            r_pd_conf <= r_rd_conf;
            r_pd_fs   <= r_rd_fs;
            r_pd_tid  <= r_rd_tid;
        end
        if (out_ld) begin
            if (i_cmd.rotate || i_cmd.emit_last) begin
                r_o_type <= EVT_END;
                r_o_tid  <= r_pd_tid;
                r_o_cls  <= r_pd_cls;
                r_o_conf <= r_pd_conf;
                r_o_box  <= r_pd_box;
                r_o_fs   <= r_pd_fs;
                r_o_last <= i_cmd.emit_last;
            end else begin
                r_o_cls  <= r_cls;
                r_o_conf <= r_conf;
                r_o_box  <= r_box;
                r_o_fs   <= r_fs;
                r_o_last <= 1'b1;
                if (r_have_best) begin
                    r_o_type <= EVT_UPDATE;
                    r_o_tid  <= r_best_tid;
                end else if (full) begin
                    r_o_type <= EVT_DROPPED;
                    r_o_tid  <= 32'h0;
                end else begin
                    r_o_type <= EVT_START;
                    r_o_tid  <= r_next_id;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_w         <= '0;
            r_next_id   <= '0;
            r_have_best <= 1'b0;
            r_pv        <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cmd.prep) begin
                r_idx       <= '0;
                r_w         <= '0;
                r_have_best <= 1'b0;
            end
            if (i_cmd.next_idx) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.keep) begin
                r_w <= r_w + CW'(1);
            end
            if (i_cmd.take_best) begin
                r_have_best <= 1'b1;
            end
            if (i_cmd.fin_det && !r_have_best && !full) begin
                r_count   <= r_count + CW'(1);
                r_next_id <= r_next_id + 32'd1;
            end
            if (i_cmd.fin_sweep) begin
                r_count <= r_w;
            end
            if (i_cmd.hold) begin
                r_pv <= 1'b1;
            end else if (i_cmd.emit_last) begin
                r_pv <= 1'b0;
            end
            if (out_ld) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid          = r_ov;
    assign o_evt_kind       = r_o_type;
    assign o_track_id       = r_o_tid;
    assign o_out_class      = r_o_cls;
    assign o_out_confidence = r_o_conf;
    assign o_out_x1         = r_o_box[0 +: CB];
    assign o_out_y1         = r_o_box[CB +: CB];
    assign o_out_x2         = r_o_box[2*CB +: CB];
    assign o_out_y2         = r_o_box[3*CB +: CB];
    assign o_out_frame_w    = r_o_fs[12:0];
    assign o_out_frame_h    = r_o_fs[25:13];
    assign o_last           = r_o_last;

endmodule

// ===== sv/iou_track_event_table_unit.sv =====
// Top level of the IoU track event table: configuration registers, controller and datapath.
// Depends on iou_pkg, iou_det_if, iou_evt_if, iou_ctrl and iou_dp.
//
// Detection items and end-of-frame items enter on i_det; track events leave on o_evt,
// each group of events closed by an item with last set. An ignored detection or a
// sweep that ends nothing produces no item. The three configuration registers sit on
// an APB port at byte addresses 0, 4 and 8 and must be written only while the block is
// idle; the block itself does not enforce this. One item is worked on at a time.
// A detection scans every active track slot in turn through the single-port track
// memory; each slot that passes the class and threshold test also goes through the
// shared multiplier. An end-of-frame sweep makes one memory read per track.
// Results wait in an output register, so a stalled receiver holds the block only at
// the end of a detection or when a further end event must be written. Reset empties
// the table, zeroes the track numbering and restores the register defaults.
module iou_track_event_table_unit import iou_pkg::*; #(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iou_det_if.sink           i_det,
    iou_evt_if.source         o_evt,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] r_iou_thr;
    logic [15:0] r_upd_int;
    logic [15:0] r_lost_to;
    logic [1:0]  reg_idx;
    t_cmd        cmd;
    t_sts        sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_thr <= RST_IOU_THR;
            r_upd_int <= RST_UPD_INT;
            r_lost_to <= RST_LOST_TO;
        end else if (psel && penable && pwrite) begin
            if (reg_idx == REG_IOU_THR) begin
                r_iou_thr <= pwdata[15:0];
            end
            if (reg_idx == REG_UPD_INT) begin
                r_upd_int <= pwdata[15:0];
            end
            if (reg_idx == REG_LOST_TO) begin
                r_lost_to <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        prdata = 32'h0;
        if (reg_idx == REG_IOU_THR) begin
            prdata = {16'h0, r_iou_thr};
        end else if (reg_idx == REG_UPD_INT) begin
            prdata = {16'h0, r_upd_int};
        end else if (reg_idx == REG_LOST_TO) begin
            prdata = {16'h0, r_lost_to};
        end
    end

    iou_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_det.valid),
        .o_ready (i_det.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    iou_dp #(
        .MAX_TRACKS (MAX_TRACKS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_iou_thr        (r_iou_thr),
        .i_upd_int        (r_upd_int),
        .i_lost_to        (r_lost_to),
        .i_op             (i_det.op),
        .i_class_id       (i_det.class_id),
        .i_confidence     (i_det.confidence),
        .i_x1             (i_det.x1),
        .i_y1             (i_det.y1),
        .i_x2             (i_det.x2),
        .i_y2             (i_det.y2),
        .i_frame_w        (i_det.frame_w),
        .i_frame_h        (i_det.frame_h),
        .i_now_ms         (i_det.now_ms),
        .o_valid          (o_evt.valid),
        .i_ready          (o_evt.ready),
        .o_evt_kind       (o_evt.evt_kind),
        .o_track_id       (o_evt.track_id),
        .o_out_class      (o_evt.out_class),
        .o_out_confidence (o_evt.out_confidence),
        .o_out_x1         (o_evt.out_x1),
        .o_out_y1         (o_evt.out_y1),
        .o_out_x2         (o_evt.out_x2),
        .o_out_y2         (o_evt.out_y2),
        .o_out_frame_w    (o_evt.out_frame_w),
        .o_out_frame_h    (o_evt.out_frame_h),
        .o_last           (o_evt.last)
    );

    a_fin_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin_det |-> sts.out_free)
        else $error("final detection step issued while the event register is busy");

    a_rotate_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rotate || cmd.emit_last) |-> (sts.out_free && sts.pend_valid))
        else $error("end event issued without a pending track or a free register");

    a_single_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_item, cmd.rd, cmd.fin_det, cmd.fin_sweep}))
        else $error("conflicting controller commands");

endmodule

// ===== sim/tb_iou_checker.sv =====
// Checker for the IoU track event table: watches the detection, event and APB channels.
// Depends on iou_pkg, iou_det_if and iou_evt_if; predicts events and compares them.
`timescale 1ns / 100ps

module tb_iou_checker import iou_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iou_det_if                det,
    iou_evt_if                evt,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                o_fail_count,
    output int                o_pending
);
    localparam int NTRK = 16;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [7:0]  cls;
        logic [15:0] conf;
        logic [11:0] x1, y1, x2, y2;
        logic [12:0] fw, fh;
        logic        last;
    } track_event_t;

    track_event_t expected_events[$];

    logic [15:0] thr_q16, upd_interval, lost_timeout;
    logic        trk_valid[NTRK];
    logic        trk_matched[NTRK];
    logic [7:0]  trk_cls[NTRK];
    logic [11:0] trk_x1[NTRK], trk_y1[NTRK], trk_x2[NTRK], trk_y2[NTRK];
    logic [15:0] trk_conf[NTRK];
    logic [12:0] trk_fw[NTRK], trk_fh[NTRK];
    logic [31:0] trk_id[NTRK], trk_seen[NTRK], trk_report[NTRK];
    logic [31:0] next_id;
    int          fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_events.size();

    function automatic longint unsigned span(logic [11:0] lo, logic [11:0] hi);
        return (hi > lo) ? longint'(hi - lo) : 0;
    endfunction

    function automatic logic [11:0] max12(logic [11:0] a, logic [11:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [11:0] min12(logic [11:0] a, logic [11:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic track_event_t track_event(logic [1:0] kind, int s);
        track_event_t e;
        e.kind = kind;     e.id = trk_id[s];    e.cls = trk_cls[s];  e.conf = trk_conf[s];
        e.x1 = trk_x1[s];  e.y1 = trk_y1[s];    e.x2 = trk_x2[s];    e.y2 = trk_y2[s];
        e.fw = trk_fw[s];  e.fh = trk_fh[s];    e.last = 1'b0;
        return e;
    endfunction

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic shift_track(int dst, int src);
        trk_valid[dst] = trk_valid[src];  trk_matched[dst] = trk_matched[src];
        trk_cls[dst] = trk_cls[src];      trk_conf[dst] = trk_conf[src];
        trk_x1[dst] = trk_x1[src];        trk_y1[dst] = trk_y1[src];
        trk_x2[dst] = trk_x2[src];        trk_y2[dst] = trk_y2[src];
        trk_fw[dst] = trk_fw[src];        trk_fh[dst] = trk_fh[src];
        trk_id[dst] = trk_id[src];        trk_seen[dst] = trk_seen[src];
        trk_report[dst] = trk_report[src];
    endtask

    task automatic predict_tracker_events();
        track_event_t    batch[$];
        track_event_t    e;
        logic [31:0]     now;
        longint unsigned area_d, inter, uni, best_i, best_u;
        int              w, best, count;

        now = det.now_ms;
        if (det.op == OP_SWEEP) begin
            w = 0;
            for (int r = 0; r < NTRK; r++) begin
                if (!trk_valid[r]) continue;
                if (!trk_matched[r] && (now - trk_seen[r]) >= {16'd0, lost_timeout}) begin
                    batch.insert(batch.size(), track_event(EVT_END, r));
                    continue;
                end
                if (w != r) shift_track(w, r);
                w++;
            end
            for (int r = 0; r < NTRK; r++) begin
                if (r >= w) trk_valid[r] = 1'b0;
                trk_matched[r] = 1'b0;
            end
        end else if (det.confidence != 16'd0) begin
            area_d = span(det.x1, det.x2) * span(det.y1, det.y2);
            best_i = 0;
            best_u = 1;
            best = -1;
            count = 0;
            for (int s = 0; s < NTRK; s++) begin
                if (!trk_valid[s]) continue;
                count++;
                if (trk_cls[s] != det.class_id) continue;
                inter = span(max12(trk_x1[s], det.x1), min12(trk_x2[s], det.x2)) *
                        span(max12(trk_y1[s], det.y1), min12(trk_y2[s], det.y2));
                uni = span(trk_x1[s], trk_x2[s]) * span(trk_y1[s], trk_y2[s]) + area_d - inter;
                if (inter == 0 || uni == 0) continue;
                if (inter * 65536 >= longint'(thr_q16) * uni && inter * best_u > best_i * uni) begin
                    best = s;
                    best_i = inter;
                    best_u = uni;
                end
            end
            if (best < 0 && count >= NTRK) begin
                e.kind = EVT_DROPPED; e.id = 32'd0; e.cls = det.class_id;
                e.conf = det.confidence;
                e.x1 = det.x1; e.y1 = det.y1; e.x2 = det.x2; e.y2 = det.y2;
                e.fw = det.frame_w; e.fh = det.frame_h; e.last = 1'b0;
                batch.insert(batch.size(), e);
            end else begin
                if (best < 0) begin
                    best = count;
                    trk_valid[best] = 1'b1;
                    trk_cls[best] = det.class_id;
                    trk_id[best] = next_id;
                    next_id = next_id + 32'd1;
                    trk_report[best] = now;
                end
                trk_x1[best] = det.x1; trk_y1[best] = det.y1;
                trk_x2[best] = det.x2; trk_y2[best] = det.y2;
                trk_conf[best] = det.confidence;
                trk_fw[best] = det.frame_w; trk_fh[best] = det.frame_h;
                trk_seen[best] = now;
                trk_matched[best] = 1'b1;
                if (best == count && count < NTRK && trk_report[best] == now
                    && trk_id[best] == next_id - 32'd1 && batch.size() == 0
                    && !(best_u != 1)) begin
                    batch.insert(batch.size(), track_event(EVT_START, best));
                end else if ((now - trk_report[best]) >= {16'd0, upd_interval}) begin
                    trk_report[best] = now;
                    batch.insert(batch.size(), track_event(EVT_UPDATE, best));
                end
            end
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[k]) expected_events.insert(expected_events.size(), batch[k]);
    endtask

    always @(posedge i_clk) begin
        track_event_t exp_e;
        if (!i_rst_n) begin
            thr_q16 = RST_IOU_THR;
            upd_interval = RST_UPD_INT;
            lost_timeout = RST_LOST_TO;
            next_id = 32'd0;
            for (int s = 0; s < NTRK; s++) begin
                trk_valid[s] = 1'b0;
                trk_matched[s] = 1'b0;
            end
            expected_events.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_IOU_THR: thr_q16 = pwdata[15:0];
                    REG_UPD_INT: upd_interval = pwdata[15:0];
                    REG_LOST_TO: lost_timeout = pwdata[15:0];
                    default: ;
                endcase
            end
            if (evt.valid && evt.ready) begin
                if (expected_events.size() == 0) begin
                    report($sformatf("event kind %0d id %0d with nothing expected",
                                     evt.evt_kind, evt.track_id));
                end else begin
                    exp_e = expected_events.pop_front();
                    if (evt.evt_kind !== exp_e.kind)
                        report($sformatf("event kind %0d, expected %0d", evt.evt_kind, exp_e.kind));
                    if (evt.track_id !== exp_e.id)
                        report($sformatf("track_id %0d, expected %0d", evt.track_id, exp_e.id));
                    if (evt.out_class !== exp_e.cls)
                        report($sformatf("out_class %0d, expected %0d", evt.out_class, exp_e.cls));
                    if (evt.out_confidence !== exp_e.conf)
                        report($sformatf("out_confidence %0d, expected %0d",
                                         evt.out_confidence, exp_e.conf));
                    if ({evt.out_x1, evt.out_y1, evt.out_x2, evt.out_y2} !==
                        {exp_e.x1, exp_e.y1, exp_e.x2, exp_e.y2})
                        report($sformatf("box %0d,%0d,%0d,%0d, expected %0d,%0d,%0d,%0d",
                                         evt.out_x1, evt.out_y1, evt.out_x2, evt.out_y2,
                                         exp_e.x1, exp_e.y1, exp_e.x2, exp_e.y2));
                    if ({evt.out_frame_w, evt.out_frame_h} !== {exp_e.fw, exp_e.fh})
                        report($sformatf("frame %0dx%0d, expected %0dx%0d", evt.out_frame_w,
                                         evt.out_frame_h, exp_e.fw, exp_e.fh));
                    if (evt.last !== exp_e.last)
                        report($sformatf("last %0d, expected %0d", evt.last, exp_e.last));
                end
            end
            if (det.valid && det.ready) predict_tracker_events();
        end
    end
endmodule

// ===== sim/tb_top.sv =====
// Testbench top of the IoU track event table: clock, reset, stimulus and verdict.
// Depends on iou_pkg, the channel interfaces, the block itself and tb_iou_checker.
`timescale 1ns / 100ps

module tb_top;
    import iou_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int IDLE_WAIT   = 200;
    localparam int NOBJ        = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count, pending;
    int                cycles = 0;
    int                sent_items = 0;
    bit                no_idle = 1'b0;
    bit                stall_req = 1'b0;
    logic [31:0]       now_ms = 32'd0;

    bit                obj_alive[NOBJ];
    logic [7:0]        obj_cls[NOBJ];
    int                obj_x[NOBJ], obj_y[NOBJ], obj_w[NOBJ], obj_h[NOBJ];

    iou_det_if #(.COORD_BITS(12)) det_ch();
    iou_evt_if #(.COORD_BITS(12)) evt_ch();

    iou_track_event_table_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_det(det_ch), .o_evt(evt_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tb_iou_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .det(det_ch), .evt(evt_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        det_ch.valid = 1'b0;
        det_ch.op = OP_DETECT;
        det_ch.class_id = '0;
        det_ch.confidence = '0;
        det_ch.x1 = '0; det_ch.y1 = '0; det_ch.x2 = '0; det_ch.y2 = '0;
        det_ch.frame_w = '0; det_ch.frame_h = '0; det_ch.now_ms = '0;
        evt_ch.ready = 1'b0;
    end

    initial begin
        int r;
        repeat (9) @(posedge i_clk);
        forever begin
            if (stall_req) begin
                evt_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                stall_req = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (no_idle || r < 60) begin
                evt_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                evt_ch.ready <= 1'b0;
                if (r < 95) repeat ($urandom_range(1, 3)) @(posedge i_clk);
                else repeat ($urandom_range(10, 60)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic op, logic [7:0] cls, logic [15:0] conf,
                             int x1, int y1, int x2, int y2, logic [12:0] fw, logic [12:0] fh);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = (no_idle || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        if (gap > 0) begin
            det_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        det_ch.valid <= 1'b1;
        det_ch.op <= op;
        det_ch.class_id <= cls;
        det_ch.confidence <= conf;
        det_ch.x1 <= x1[11:0]; det_ch.y1 <= y1[11:0];
        det_ch.x2 <= x2[11:0]; det_ch.y2 <= y2[11:0];
        det_ch.frame_w <= fw; det_ch.frame_h <= fh;
        det_ch.now_ms <= now_ms;
        do @(posedge i_clk); while (!det_ch.ready);
        if (op == OP_SWEEP || conf != 16'd0) sent_items++;
    endtask

    task automatic wait_drained();
        det_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] thr, logic [15:0] upd, logic [15:0] lost);
        write_reg(REG_IOU_THR, thr);
        write_reg(REG_UPD_INT, upd);
        write_reg(REG_LOST_TO, lost);
    endtask

    function automatic int clip(int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    function automatic logic [12:0] rand_frame();
        return ($urandom_range(0, 9) == 0) ? 13'd4096 : 13'($urandom_range(0, 4095));
    endfunction

    function automatic logic [15:0] rand_conf();
        return ($urandom_range(0, 49) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    endfunction

    task automatic spawn_object(int k);
        obj_alive[k] = 1'b1;
        obj_cls[k] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        obj_w[k] = $urandom_range(20, 400);
        obj_h[k] = $urandom_range(20, 400);
        obj_x[k] = $urandom_range(0, 4095 - obj_w[k]);
        obj_y[k] = $urandom_range(0, 4095 - obj_h[k]);
    endtask

    task automatic scene_frame();
        int r, x, y, k;
        r = $urandom_range(0, 99);
        if (r < 70) now_ms = now_ms + $urandom_range(20, 400);
        else if (r < 85) now_ms = now_ms + $urandom_range(1500, 4000);
        else if (r < 92) now_ms = $urandom;
        for (int i = 0; i < NOBJ; i++) begin
            if (obj_alive[i]) begin
                if ($urandom_range(0, 99) < 80) begin
                    obj_x[i] = clip(obj_x[i] + $urandom_range(0, 16) - 8);
                    obj_y[i] = clip(obj_y[i] + $urandom_range(0, 16) - 8);
                    x = obj_x[i];
                    y = obj_y[i];
                    send_item(OP_DETECT, obj_cls[i], rand_conf(), x, y,
                              clip(x + obj_w[i] + $urandom_range(0, 8) - 4),
                              clip(y + obj_h[i] + $urandom_range(0, 8) - 4),
                              rand_frame(), rand_frame());
                end
            end else if ($urandom_range(0, 99) < 15) begin
                spawn_object(i);
            end
        end
        if ($urandom_range(0, 99) < 6) obj_alive[$urandom_range(0, NOBJ-1)] = 1'b0;
        if ($urandom_range(0, 99) < 6) begin
            for (int i = 0; i < 18; i++) begin
                x = $urandom_range(0, 3900);
                y = $urandom_range(0, 3900);
                send_item(OP_DETECT, 8'($urandom), 16'($urandom_range(1, 65535)), x, y,
                          x + $urandom_range(1, 150), y + $urandom_range(1, 150),
                          rand_frame(), rand_frame());
            end
        end
        if ($urandom_range(0, 99) < 10) begin
            k = $urandom_range(0, 1);
            send_item(k[0], 8'($urandom), 16'($urandom), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), rand_frame(), rand_frame());
        end
        send_item(OP_SWEEP, 8'($urandom), 16'($urandom), 0, 0, 0, 0, rand_frame(), rand_frame());
    endtask

    task automatic run_scene(int target);
        int stop_at;
        stop_at = sent_items + target;
        for (int i = 0; i < NOBJ; i++) obj_alive[i] = 1'b0;
        for (int i = 0; i < 4; i++) spawn_object(i);
        while (sent_items < stop_at) scene_frame();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        now_ms = 32'd0;
        send_item(OP_DETECT, 8'd0, 16'hFFFF, 0, 0, 4095, 4095, 13'd4096, 13'd4096);
        now_ms = 32'd1000;
        send_item(OP_DETECT, 8'd0, 16'd1, 0, 0, 4095, 4095, 13'd0, 13'd0);
        now_ms = 32'd1500;
        send_item(OP_DETECT, 8'd0, 16'd7, 1, 1, 4094, 4094, 13'd640, 13'd480);
        send_item(OP_DETECT, 8'd9, 16'd0, 10, 10, 50, 50, 13'd640, 13'd480);
        send_item(OP_DETECT, 8'd1, 16'd500, 300, 300, 200, 200, 13'd1920, 13'd1080);
        send_item(OP_DETECT, 8'd1, 16'd500, 300, 300, 200, 200, 13'd1920, 13'd1080);
        send_item(OP_DETECT, 8'hFF, 16'h8000, 4095, 4095, 4095, 4095, 13'hFFF, 13'hAAA);
        send_item(OP_DETECT, 8'd2, 16'd100, 0, 0, 100, 100, 13'd800, 13'd600);
        send_item(OP_DETECT, 8'd2, 16'd100, 100, 0, 200, 100, 13'd800, 13'd600);
        send_item(OP_SWEEP, 8'd0, 16'd0, 0, 0, 0, 0, 13'd0, 13'd0);
        now_ms = 32'd2600;
        send_item(OP_DETECT, 8'd2, 16'd300, 50, 0, 150, 100, 13'd800, 13'd600);
        send_item(OP_DETECT, 8'd2, 16'd300, 2000, 2000, 2100, 2100, 13'd800, 13'd600);
        now_ms = 32'd4000;
        send_item(OP_SWEEP, 8'd0, 16'd0, 0, 0, 0, 0, 13'd0, 13'd0);
        now_ms = 32'hFFFF_FFF0;
        send_item(OP_DETECT, 8'd3, 16'd42, 10, 20, 30, 40, 13'd100, 13'd100);
        now_ms = 32'd2000;
        send_item(OP_SWEEP, 8'd0, 16'd0, 0, 0, 0, 0, 13'd0, 13'd0);
        now_ms = 32'd9000;
        send_item(OP_SWEEP, 8'd0, 16'd0, 0, 0, 0, 0, 13'd0, 13'd0);
        wait_drained();

        set_config(16'd0, 16'd0, 16'd0);
        run_scene(80);
        wait_drained();

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_scene(70);
        wait_drained();

        set_config(16'($urandom), 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 5000)));
        no_idle = 1'b1;
        run_scene(50);
        no_idle = 1'b0;
        run_scene(50);
        wait_drained();

        set_config(16'd26214, 16'd300, 16'd800);
        run_scene(40);
        stall_req = 1'b1;
        run_scene(40);
        det_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        run_scene(40);
        wait_drained();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/iou_pkg.sv
sv/iou_det_if.sv
sv/iou_evt_if.sv
sv/iou_ctrl.sv
sv/iou_dp.sv
sv/iou_track_event_table_unit.sv
sim/tb_iou_checker.sv
sim/tb_top.sv
